[design/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// hsa_pkg
// Types and constants shared by the slot allocator's controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package hsa_pkg;

   localparam int SlotCapacity = 1024;
   localparam int IndexWidth   = 10;
   localparam int CountWidth   = 11;
   localparam int TagWidth     = 32;
   localparam int SlotArgWidth = 11;
   localparam int StatusWidth  = 3;
   localparam int ActionWidth  = 2;

   localparam logic [ActionWidth-1:0] ActAlloc   = 2'd0;
   localparam logic [ActionWidth-1:0] ActFree    = 2'd1;
   localparam logic [ActionWidth-1:0] ActDisable = 2'd2;

   localparam logic [StatusWidth-1:0] StOk       = 3'd0;
   localparam logic [StatusWidth-1:0] StDisabled = 3'd1;
   localparam logic [StatusWidth-1:0] StFull     = 3'd2;
   localparam logic [StatusWidth-1:0] StMismatch = 3'd3;
   localparam logic [StatusWidth-1:0] StIgnored  = 3'd4;
   localparam logic [StatusWidth-1:0] StRange    = 3'd5;

   typedef enum logic [1:0] {
      StIdle,
      StExec,
      StGrow
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch the request, start the table and stack reads
      logic commit;   // apply the request and load the response register
      logic sweep;    // clear one new slot and push its index
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;     // response register can take a result this cycle
      logic grow_needed;  // committing now opens new slots to be pushed
      logic sweep_last;   // current sweep slot is the last new one
   } stat_type;

endpackage

[design/hsa_ram.sv]
// ----------------------------------------------------------------------------
// hsa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hsa_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hsa_ctrl.sv]
// ----------------------------------------------------------------------------
// hsa_ctrl
// Sequencer: take a request, commit it once the response register is free,
// then walk the new slots of a table growth step.
// ----------------------------------------------------------------------------
module hsa_ctrl
   import hsa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               state_in = StExec;
            end
         end
         StExec: begin
            if (stat.out_free) begin
               state_in = stat.grow_needed ? StGrow : StIdle;
            end
         end
         StGrow: begin
            if (stat.sweep_last) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         StExec: begin
            cmd.commit = stat.out_free;
         end
         StGrow: begin
            cmd.sweep = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

[design/hsa_datapath.sv]
// ----------------------------------------------------------------------------
// hsa_datapath
// Owner table, free stack, size registers and response register.
// ----------------------------------------------------------------------------
module hsa_datapath
   import hsa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [ActionWidth-1:0]  req_action,
   input  logic [TagWidth-1:0]     req_owner_tag,
   input  logic [SlotArgWidth-1:0] req_slot_index,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [StatusWidth-1:0]  rsp_status,
   output logic [IndexWidth-1:0]   rsp_granted_index
);

   localparam logic [CountWidth:0]   CapWide  = (CountWidth+1)'(SlotCapacity);
   localparam logic [CountWidth-1:0] CapCount = CountWidth'(SlotCapacity);

   // latched request
   logic [ActionWidth-1:0]  action_ff;
   logic [TagWidth-1:0]     tag_ff;
   logic [SlotArgWidth-1:0] index_ff;

   logic [CountWidth-1:0] stack_count_ff, stack_count_in;
   logic [CountWidth-1:0] used_size_ff, used_size_in;
   logic                  enabled_ff, enabled_in;
   logic [IndexWidth-1:0] sweep_ptr_ff, sweep_ptr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] rsp_status_ff;
   logic [IndexWidth-1:0]  rsp_index_ff;

   // memory ports
   logic                  own_we;
   logic [IndexWidth-1:0] own_waddr, own_raddr;
   logic [TagWidth-1:0]   own_wdata, own_rdata;
   logic                  stk_we;
   logic [IndexWidth-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   // decision for the latched request
   logic [StatusWidth-1:0] dec_status;
   logic [IndexWidth-1:0]  dec_grant;
   logic                   dec_own_wr, dec_push, dec_pop, dec_grow, dec_disable;
   logic [IndexWidth-1:0]  dec_own_addr;
   logic [TagWidth-1:0]    dec_own_data;
   logic [CountWidth:0]    grown_raw;
   logic [CountWidth-1:0]  grown;
   logic                   stack_full;

   hsa_ram #(.Width(TagWidth), .Depth(SlotCapacity)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (own_raddr),
      .rd_data (own_rdata)
   );

   hsa_ram #(.Width(IndexWidth), .Depth(SlotCapacity)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // read addresses: the request's slot and the stack top, stable until commit
   assign own_raddr = cmd.load ? req_slot_index[IndexWidth-1:0]
                               : index_ff[IndexWidth-1:0];
   assign stk_raddr = stack_count_ff[IndexWidth-1:0] - IndexWidth'(1);

   assign grown_raw = {1'b0, used_size_ff} + {2'b00, used_size_ff[CountWidth-1:1]}
                      + (CountWidth+1)'(1);
   assign grown     = (grown_raw > CapWide) ? CapCount : grown_raw[CountWidth-1:0];
   assign stack_full = (stack_count_ff == CapCount);

   always_comb begin
      dec_status   = StIgnored;
      dec_grant    = '0;
      dec_own_wr   = 1'b0;
      dec_push     = 1'b0;
      dec_pop      = 1'b0;
      dec_grow     = 1'b0;
      dec_disable  = 1'b0;
      dec_own_addr = index_ff[IndexWidth-1:0];
      dec_own_data = '0;
      unique case (action_ff)
         ActAlloc: begin
            priority if (!enabled_ff) begin
               dec_status = StDisabled;
            end else if (tag_ff == '0) begin
               dec_status = StIgnored;
            end else if (stack_count_ff != '0) begin
               dec_status   = StOk;
               dec_grant    = stk_rdata;
               dec_pop      = 1'b1;
               dec_own_wr   = 1'b1;
               dec_own_addr = stk_rdata;
               dec_own_data = tag_ff;
            end else if (used_size_ff >= CapCount) begin
               dec_status = StFull;
            end else begin
               dec_status   = StOk;
               dec_grant    = used_size_ff[IndexWidth-1:0];
               dec_grow     = 1'b1;
               dec_own_wr   = 1'b1;
               dec_own_addr = used_size_ff[IndexWidth-1:0];
               dec_own_data = tag_ff;
            end
         end
         ActFree: begin
            priority if (index_ff[SlotArgWidth-1]) begin
               dec_status = StIgnored;
            end else if ({1'b0, index_ff[IndexWidth-1:0]} >= used_size_ff) begin
               dec_status = StRange;
            end else if (tag_ff == '0 || own_rdata != tag_ff) begin
               dec_status = StMismatch;
            end else begin
               dec_status = StOk;
               dec_own_wr = 1'b1;
               dec_push   = !stack_full;
            end
         end
         ActDisable: begin
            dec_status  = StOk;
            dec_disable = 1'b1;
         end
         default: dec_status = StIgnored;
      endcase
   end

   // write ports: commit or one sweep step, never both
   always_comb begin
      own_we    = 1'b0;
      own_waddr = dec_own_addr;
      own_wdata = dec_own_data;
      stk_we    = 1'b0;
      stk_waddr = stack_count_ff[IndexWidth-1:0];
      stk_wdata = index_ff[IndexWidth-1:0];
      if (cmd.sweep) begin
         own_we    = 1'b1;
         own_waddr = sweep_ptr_ff;
         own_wdata = '0;
         stk_we    = !stack_full;
         stk_wdata = sweep_ptr_ff;
      end else if (cmd.commit) begin
         own_we = dec_own_wr;
         stk_we = dec_push;
      end
   end

   always_comb begin
      stack_count_in = stack_count_ff;
      used_size_in   = used_size_ff;
      enabled_in     = enabled_ff;
      sweep_ptr_in   = sweep_ptr_ff;
      if (cmd.sweep) begin
         sweep_ptr_in = sweep_ptr_ff + IndexWidth'(1);
         if (!stack_full) begin
            stack_count_in = stack_count_ff + CountWidth'(1);
         end
      end else if (cmd.commit) begin
         if (dec_pop) begin
            stack_count_in = stack_count_ff - CountWidth'(1);
         end
         if (dec_push) begin
            stack_count_in = stack_count_ff + CountWidth'(1);
         end
         if (dec_grow) begin
            used_size_in = grown;
            sweep_ptr_in = used_size_ff[IndexWidth-1:0] + IndexWidth'(1);
         end
         if (dec_disable) begin
            enabled_in = 1'b0;
         end
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign stat.grow_needed = dec_grow && (grown != used_size_ff + CountWidth'(1));
   assign stat.sweep_last  = ({1'b0, sweep_ptr_ff} + CountWidth'(1)) == used_size_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= '0;
         used_size_ff   <= '0;
         enabled_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stack_count_ff <= stack_count_in;
         used_size_ff   <= used_size_in;
         enabled_ff     <= enabled_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ptr_ff <= sweep_ptr_in;
      if (cmd.load) begin
         action_ff <= req_action;
         tag_ff    <= req_owner_tag;
         index_ff  <= req_slot_index;
      end
      if (cmd.commit) begin
         rsp_status_ff <= dec_status;
         rsp_index_ff  <= dec_grant;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;

endmodule

[design/handle_slot_allocator.sv]
// ----------------------------------------------------------------------------
// handle_slot_allocator
// Slot table that grants indices to nonzero owner tags and takes them back.
// ----------------------------------------------------------------------------
// One request, one response. The accept cycle starts the registered reads of
// the owner table and of the free stack top, and the execute state then
// decides and commits, loading the response register. The request port stays
// closed from acceptance until commit, and commit waits while the response
// register still holds an untaken result. An allocation that finds the free
// stack empty grows the used size from old to min(old + old/2 + 1, 1024); the
// response for slot old goes out at commit, then the sweep clears each new
// slot old+1 .. new-1 in turn and pushes its index onto the free stack, one
// slot at a time, as set by the single write port of each table. The owner
// table needs no clearing pass after reset: a slot is only read below the
// used size, and every slot there has been written by the allocation or
// growth step that brought it in. Allocation requests are refused after a
// disable until reset; frees are always served. Statuses: 0 ok, 1 disabled,
// 2 full, 3 tag mismatch, 4 ignored, 5 index out of range; granted index is
// zero unless status is ok.
// ----------------------------------------------------------------------------
module handle_slot_allocator
   import hsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] owner_tag, [42:32] slot_index, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] status, [12:3] granted_index, rest zero
);

   cmd_type  cmd;
   stat_type stat;

   logic [StatusWidth-1:0] rsp_status;
   logic [IndexWidth-1:0]  rsp_granted_index;

   // sequencer: accept, commit, then sweep new slots after a growth step
   hsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, counters and the response register
   hsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_tuser),
      .req_owner_tag     (req_tdata[TagWidth-1:0]),
      .req_slot_index    (req_tdata[TagWidth+SlotArgWidth-1:TagWidth]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index)
   );

   // pack the response: status lowest, then the granted index, zero padding
   assign rsp_tdata = {3'b000, rsp_granted_index, rsp_status};

`ifndef SYNTH
   // a committed request always leaves a result in the response register
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not produce a response");

   // the request port stays closed throughout a growth sweep
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !req_tready)
      else $error("request accepted during a growth sweep");

   // a granted index is only given with an ok status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != StOk) |-> rsp_granted_index == '0)
      else $error("nonzero index on a refused request");

   // a sweep step is never issued together with a commit or a load
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !cmd.commit && !cmd.load)
      else $error("sweep overlaps a request step");
`endif

endmodule
